// ===== hdl/rgbc_pkg.sv =====
// Package for the RGBC to HSL converter: widths and constants.
// No dependencies.
package rgbc_pkg;
    localparam int COUNT_BITS_DEF = 16;
    localparam int CH_BITS        = 8;
    localparam int HUE_BITS       = 9;
    localparam int SAT_BITS       = 7;
    // quotient bits kept by the normalizing divider (256 means saturate)
    localparam int NQ_BITS        = 9;
    // bits of the hue and saturation dividers
    localparam int HQ_BITS        = 6;
    localparam int SQ_BITS        = 7;

    typedef struct packed {
        logic [CH_BITS-1:0] r;
        logic [CH_BITS-1:0] g;
        logic [CH_BITS-1:0] b;
        logic               cz;
    } t_rgb;
endpackage

// ===== hdl/rgbc_norm_div.sv =====
// Pipelined restoring divider for ch*255/clear, one quotient bit per stage.
// Uses rgbc_pkg.
module rgbc_norm_div #(
    parameter int COUNT_BITS = rgbc_pkg::COUNT_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [COUNT_BITS-1:0]       i_num,
    input  logic [COUNT_BITS-1:0]       i_den,
    output logic [rgbc_pkg::CH_BITS-1:0] o_q
);
    localparam int NQ = rgbc_pkg::NQ_BITS;
    localparam int PW = COUNT_BITS + 8;
    localparam int RW = COUNT_BITS + 1;

    // The quotient saturates at 255, so only its low NQ bits matter;
    // pre-check whether ch*255 >= 256*clear (saturate outright).
    logic [PW-1:0]         w_prod;
    logic                  w_sat;
    assign w_prod = PW'({8'd0, i_num} * PW'(255));
    assign w_sat  = w_prod >= {i_den, 8'd0};

    logic [RW-1:0]         r_rem [NQ];
    logic [PW-1:0]         r_num [NQ];
    logic [COUNT_BITS-1:0] r_den [NQ];
    logic [NQ-1:0]         r_q   [NQ];
    logic                  r_sat [NQ];

    logic [RW-1:0] w_try [NQ];
    logic [RW:0]   w_dif [NQ];

    // One quotient bit per stage, bits 7 down to 0 (sat flag covers bit 8).
    always_comb begin
        for (int s = 0; s < NQ; s++) begin
            w_try[s] = '0;
            w_dif[s] = '0;
        end
        for (int s = 1; s < NQ; s++) begin
            w_try[s] = {r_rem[s-1][RW-2:0], r_num[s-1][8 - s]};
            w_dif[s] = {1'b0, w_try[s]} - {2'b0, r_den[s-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {1'b0, w_prod[PW-1:8]};
            r_num[0] <= w_prod;
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_sat[0] <= w_sat;
            for (int s = 1; s < NQ; s++) begin
                r_num[s] <= r_num[s-1];
                r_den[s] <= r_den[s-1];
                r_sat[s] <= r_sat[s-1];
                if (!w_dif[s][RW]) begin
                    r_rem[s] <= w_dif[s][RW-1:0];
                    r_q[s]   <= {r_q[s-1][NQ-2:0], 1'b1};
                end else begin
                    r_rem[s] <= w_try[s];
                    r_q[s]   <= {r_q[s-1][NQ-2:0], 1'b0};
                end
            end
        end
    end

    assign o_q = r_sat[NQ-1] ? 8'hFF : r_q[NQ-1][7:0];

    // reset is unused in data path; keep port for uniformity
    logic w_unused;
    assign w_unused = i_rst_n;
endmodule

// ===== hdl/rgbc_to_hsl_converter_top.sv =====
// Top level of the RGBC to HSL converter.
// Uses rgbc_pkg and rgbc_norm_div.
//
// Usage: one sensor reading (red, green, blue, clear counts) enters on the
// input channel (i_valid/o_ready) and one word leaves on the output channel
// (o_valid/i_ready): normalized RGB, hue, saturation, lightness and a flag
// for a zero clear count.
// Throughput: one word per cycle unless the receiver stalls. Stages: the
// normalizing divider (one quotient bit per stage), min/max and sector setup
// (stages A and B), hue and saturation division (one bit per stage), hue
// offset (stage H), then the output register.
// The whole pipeline advances only when its last stage is free or being
// taken, so a stalled receiver freezes every stage; o_ready is low whenever
// an output word waits and i_ready is low, even with bubbles in the pipe.
// Reset clears the valid bits of all stages; no words are in flight after.
module rgbc_to_hsl_converter_top #(
    parameter int COUNT_BITS = rgbc_pkg::COUNT_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [COUNT_BITS-1:0]  i_red_count,
    input  logic [COUNT_BITS-1:0]  i_green_count,
    input  logic [COUNT_BITS-1:0]  i_blue_count,
    input  logic [COUNT_BITS-1:0]  i_clear_count,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [7:0]             o_norm_red,
    output logic [7:0]             o_norm_green,
    output logic [7:0]             o_norm_blue,
    output logic [8:0]             o_hue_degrees,
    output logic [6:0]             o_saturation_pct,
    output logic [7:0]             o_lightness,
    output logic                   o_clear_zero
);
    localparam int ND  = rgbc_pkg::NQ_BITS;
    localparam int HQ  = rgbc_pkg::HQ_BITS;
    localparam int SQ  = rgbc_pkg::SQ_BITS;
    localparam int DIV = (HQ > SQ) ? HQ : SQ;
    localparam int LAT = ND + 2 + DIV + 2;

    // valid chain; advance everything when the output register frees
    logic [LAT-1:0] r_vld;
    logic           w_adv;
    assign w_adv   = !r_vld[LAT-1] || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Normalize the three channels
    logic [7:0] w_nr, w_ng, w_nb;
    rgbc_norm_div #(.COUNT_BITS(COUNT_BITS)) u_div_r (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv),
        .i_num(i_red_count), .i_den(i_clear_count), .o_q(w_nr));
    rgbc_norm_div #(.COUNT_BITS(COUNT_BITS)) u_div_g (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv),
        .i_num(i_green_count), .i_den(i_clear_count), .o_q(w_ng));
    rgbc_norm_div #(.COUNT_BITS(COUNT_BITS)) u_div_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv),
        .i_num(i_blue_count), .i_den(i_clear_count), .o_q(w_nb));

    logic r_cz [ND];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_cz[0] <= (i_clear_count == '0);
            for (int s = 1; s < ND; s++) r_cz[s] <= r_cz[s-1];
        end
    end

    // Stage A: max, min, sector
    rgbc_pkg::t_rgb r_a;
    logic [7:0] r_a_mx, r_a_mn;
    logic [1:0] r_a_sec;
    logic [7:0] w_mx, w_mn;
    logic [1:0] w_sec;
    always_comb begin
        w_mx = w_nr; w_sec = 2'd0;
        if (w_ng > w_mx) begin w_mx = w_ng; w_sec = 2'd1; end
        if (w_nb > w_mx) begin w_mx = w_nb; w_sec = 2'd2; end
        w_mn = w_nr;
        if (w_ng < w_mn) w_mn = w_ng;
        if (w_nb < w_mn) w_mn = w_nb;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a     <= '{r: w_nr, g: w_ng, b: w_nb, cz: r_cz[ND-1]};
            r_a_mx  <= w_mx;
            r_a_mn  <= w_mn;
            r_a_sec <= w_sec;
        end
    end

    // Stage B: differences, signs, dividends and divisors
    rgbc_pkg::t_rgb r_b;
    logic [7:0]  r_b_d;
    logic [7:0]  r_b_lt;
    logic [13:0] r_b_hn;    // 60*|num|, at most 60*d
    logic        r_b_hneg;
    logic [1:0]  r_b_sec;
    logic [14:0] r_b_sn;    // d*100
    logic [8:0]  r_b_sd;
    logic [8:0] w_hd;
    logic       w_hneg;
    logic [8:0] w_sum;
    always_comb begin
        w_hd = '0;
        unique case (r_a_sec)
            2'd0:    w_hd = {1'b0, r_a.g} - {1'b0, r_a.b};
            2'd1:    w_hd = {1'b0, r_a.b} - {1'b0, r_a.r};
            default: w_hd = {1'b0, r_a.r} - {1'b0, r_a.g};
        endcase
        w_hneg = w_hd[8];
        if (w_hneg) w_hd = -w_hd;
        w_sum = {1'b0, r_a_mx} + {1'b0, r_a_mn};
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b      <= r_a;
            r_b_d    <= r_a_mx - r_a_mn;
            r_b_lt   <= w_sum[8:1];
            r_b_hn   <= {6'd0, w_hd[7:0]} * 14'd60;
            r_b_hneg <= w_hneg;
            r_b_sec  <= r_a_sec;
            r_b_sn   <= {7'd0, r_a_mx - r_a_mn} * 15'd100;
            r_b_sd   <= (w_sum[8:1] <= 8'd127) ? w_sum : 9'd510 - w_sum;
        end
    end

    // Division pipeline: hue 60*|n|/d (<=60, 6 bits), sat d*100/den (<=100)
    rgbc_pkg::t_rgb r_p [DIV];
    logic [7:0]  r_p_d   [DIV];
    logic [7:0]  r_p_lt  [DIV];
    logic        r_p_neg [DIV];
    logic [1:0]  r_p_sec [DIV];
    logic [14:0] r_hr    [DIV];
    logic [14:0] r_hnum  [DIV];
    logic [SQ-1:0] r_hq  [DIV];
    logic [15:0] r_sr    [DIV];
    logic [14:0] r_snum  [DIV];
    logic [8:0]  r_sd    [DIV];
    logic [SQ-1:0] r_sq  [DIV];

    logic [14:0] w_hr_in [DIV+1];
    logic [14:0] w_hn_in [DIV+1];
    logic [SQ-1:0] w_hq_in [DIV+1];
    logic [15:0] w_sr_in [DIV+1];
    logic [14:0] w_sn_in [DIV+1];
    logic [SQ-1:0] w_sq_in [DIV+1];
    logic [7:0]  w_dd_in [DIV+1];
    logic [8:0]  w_sdd_in [DIV+1];

    // Restoring step per stage, one quotient bit each, MSB first
    always_comb begin
        w_hr_in[0] = '0; w_hn_in[0] = {1'b0, r_b_hn}; w_hq_in[0] = '0;
        w_sr_in[0] = '0; w_sn_in[0] = r_b_sn;         w_sq_in[0] = '0;
        w_dd_in[0] = r_b_d; w_sdd_in[0] = r_b_sd;
        for (int s = 1; s <= DIV; s++) begin
            w_hr_in[s] = r_hr[s-1]; w_hn_in[s] = r_hnum[s-1]; w_hq_in[s] = r_hq[s-1];
            w_sr_in[s] = r_sr[s-1]; w_sn_in[s] = r_snum[s-1]; w_sq_in[s] = r_sq[s-1];
            w_dd_in[s] = r_p_d[s-1]; w_sdd_in[s] = r_sd[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int s = 0; s < DIV; s++) begin
                if (s == 0) begin
                    r_p[0] <= r_b; r_p_d[0] <= r_b_d; r_p_lt[0] <= r_b_lt;
                    r_p_neg[0] <= r_b_hneg; r_p_sec[0] <= r_b_sec;
                end else begin
                    r_p[s] <= r_p[s-1]; r_p_d[s] <= r_p_d[s-1];
                    r_p_lt[s] <= r_p_lt[s-1];
                    r_p_neg[s] <= r_p_neg[s-1]; r_p_sec[s] <= r_p_sec[s-1];
                end
                r_sd[s] <= w_sdd_in[s];
                // hue: remainder starts as n>>(SQ-1), shift in next bit
                begin
                    logic [14:0] hrem;
                    logic [15:0] srem;
                    if (s == 0) begin
                        hrem = 15'(w_hn_in[s] >> (SQ - 1));
                        srem = 16'(w_sn_in[s] >> (SQ - 1));
                    end else begin
                        hrem = {w_hr_in[s][13:0], w_hn_in[s][SQ-1-s]};
                        srem = {w_sr_in[s][14:0], w_sn_in[s][SQ-1-s]};
                    end
                    if (hrem >= {7'd0, w_dd_in[s]}) begin
                        r_hr[s] <= hrem - {7'd0, w_dd_in[s]};
                        r_hq[s] <= {w_hq_in[s][SQ-2:0], 1'b1};
                    end else begin
                        r_hr[s] <= hrem;
                        r_hq[s] <= {w_hq_in[s][SQ-2:0], 1'b0};
                    end
                    if (srem >= {7'd0, w_sdd_in[s]}) begin
                        r_sr[s] <= srem - {7'd0, w_sdd_in[s]};
                        r_sq[s] <= {w_sq_in[s][SQ-2:0], 1'b1};
                    end else begin
                        r_sr[s] <= srem;
                        r_sq[s] <= {w_sq_in[s][SQ-2:0], 1'b0};
                    end
                end
                r_hnum[s] <= w_hn_in[s];
                r_snum[s] <= w_sn_in[s];
            end
        end
    end

    // Stage H: apply sign and sector offset, wrap at 360
    rgbc_pkg::t_rgb r_h;
    logic [8:0] r_h_hue;
    logic [6:0] r_h_sat;
    logic [7:0] r_h_lt;
    logic       r_h_grey;
    logic [9:0] w_hue;
    logic [9:0] w_q;
    always_comb begin
        w_q = {3'd0, r_hq[DIV-1]};
        unique case (r_p_sec[DIV-1])
            2'd0:    w_hue = r_p_neg[DIV-1] ? 10'd360 - w_q : w_q;
            2'd1:    w_hue = r_p_neg[DIV-1] ? 10'd120 - w_q : 10'd120 + w_q;
            default: w_hue = r_p_neg[DIV-1] ? 10'd240 - w_q : 10'd240 + w_q;
        endcase
        if (w_hue >= 10'd360) w_hue = w_hue - 10'd360;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_h      <= r_p[DIV-1];
            r_h_hue  <= w_hue[8:0];
            r_h_sat  <= r_sq[DIV-1];
            r_h_lt   <= r_p_lt[DIV-1];
            r_h_grey <= (r_p_d[DIV-1] == 8'd0);
        end
    end

    // Output register: force all zeros on zero clear, zero hue and saturation on grey
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_clear_zero     <= r_h.cz;
            o_norm_red       <= r_h.cz ? 8'd0 : r_h.r;
            o_norm_green     <= r_h.cz ? 8'd0 : r_h.g;
            o_norm_blue      <= r_h.cz ? 8'd0 : r_h.b;
            o_lightness      <= r_h.cz ? 8'd0 : r_h_lt;
            o_hue_degrees    <= (r_h.cz || r_h_grey) ? 9'd0 : r_h_hue;
            o_saturation_pct <= (r_h.cz || r_h_grey) ? 7'd0 : r_h_sat;
        end
    end
endmodule

// ===== bench/rgbc_hsl_checker.sv =====
// Checker for the RGBC to HSL converter: watches both channels, predicts
// each output word from the accepted reading and compares field by field.
// Depends on the converter's port list only.
module rgbc_hsl_checker #(
    parameter int COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  o_ready,
    input  logic [COUNT_BITS-1:0] i_red_count,
    input  logic [COUNT_BITS-1:0] i_green_count,
    input  logic [COUNT_BITS-1:0] i_blue_count,
    input  logic [COUNT_BITS-1:0] i_clear_count,
    input  logic                  o_valid,
    input  logic                  i_ready,
    input  logic [7:0]            o_norm_red,
    input  logic [7:0]            o_norm_green,
    input  logic [7:0]            o_norm_blue,
    input  logic [8:0]            o_hue_degrees,
    input  logic [6:0]            o_saturation_pct,
    input  logic [7:0]            o_lightness,
    input  logic                  o_clear_zero,
    output int                    fail_count,
    output int                    pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [8:0] hue;
        logic [6:0] sat;
        logic [7:0] light;
        logic       cz;
    } t_hsl_word;

    t_hsl_word hsl_queue[$];

    function automatic int scale_channel(longint ch, longint clr);
        longint q;
        q = (ch * 255) / clr;
        return (q > 255) ? 255 : int'(q);
    endfunction

    // Compute the expected word for one reading
    function automatic t_hsl_word predict_hsl(longint rc, longint gc, longint bc,
                                              longint cc);
        t_hsl_word w;
        int r, g, b, mx, mn, d, hue, sat, light;
        w = '0;
        if (cc == 0) begin
            w.cz = 1'b1;
            return w;
        end
        r = scale_channel(rc, cc);
        g = scale_channel(gc, cc);
        b = scale_channel(bc, cc);
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        light = (mx + mn) / 2;
        hue = 0;
        sat = 0;
        if (d != 0) begin
            // SV int division truncates toward zero, as the hue rule wants
            if (mx == r) begin
                hue = (60 * (g - b)) / d;
                if (g < b) hue += 360;
            end else if (mx == g) begin
                hue = (60 * (b - r)) / d + 120;
            end else begin
                hue = (60 * (r - g)) / d + 240;
            end
            if (hue >= 360) hue -= 360;
            if (light <= 127) sat = (d * 100) / (mx + mn);
            else sat = (d * 100) / (510 - (mx + mn));
        end
        w.r = r[7:0];
        w.g = g[7:0];
        w.b = b[7:0];
        w.hue = hue[8:0];
        w.sat = sat[6:0];
        w.light = light[7:0];
        return w;
    endfunction

    assign pending_count = hsl_queue.size();

    // Predict on input words, compare on output words
    always @(posedge i_clk) begin
        t_hsl_word exp_w;
        if (i_rst_n && i_valid && o_ready)
            hsl_queue.push_back(predict_hsl(i_red_count, i_green_count, i_blue_count,
                                            i_clear_count));
        if (i_rst_n && o_valid && i_ready) begin
            if (hsl_queue.size() == 0) begin
                $error("output word with nothing expected");
                fail_count++;
            end else begin
                exp_w = hsl_queue.pop_front();
                if (o_norm_red !== exp_w.r) begin
                    $error("norm_red exp %0d got %0d", exp_w.r, o_norm_red);
                    fail_count++;
                end
                if (o_norm_green !== exp_w.g) begin
                    $error("norm_green exp %0d got %0d", exp_w.g, o_norm_green);
                    fail_count++;
                end
                if (o_norm_blue !== exp_w.b) begin
                    $error("norm_blue exp %0d got %0d", exp_w.b, o_norm_blue);
                    fail_count++;
                end
                if (o_hue_degrees !== exp_w.hue) begin
                    $error("hue_degrees exp %0d got %0d", exp_w.hue, o_hue_degrees);
                    fail_count++;
                end
                if (o_saturation_pct !== exp_w.sat) begin
                    $error("saturation_pct exp %0d got %0d", exp_w.sat,
                           o_saturation_pct);
                    fail_count++;
                end
                if (o_lightness !== exp_w.light) begin
                    $error("lightness exp %0d got %0d", exp_w.light, o_lightness);
                    fail_count++;
                end
                if (o_clear_zero !== exp_w.cz) begin
                    $error("clear_zero exp %0d got %0d", exp_w.cz, o_clear_zero);
                    fail_count++;
                end
            end
        end
    end

    initial fail_count = 0;
endmodule

// ===== bench/tb_top.sv =====
// Testbench top for the RGBC to HSL converter: drives readings with random
// gaps and stalls, gives the verdict. Depends on rgbc_pkg, the converter
// and rgbc_hsl_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = rgbc_pkg::COUNT_BITS_DEF;
    localparam int N_RANDOM = 880;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 40;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          o_ready;
    logic [CB-1:0] i_red_count = '0;
    logic [CB-1:0] i_green_count = '0;
    logic [CB-1:0] i_blue_count = '0;
    logic [CB-1:0] i_clear_count = '0;
    logic          o_valid;
    logic          i_ready = 1'b0;
    logic [7:0]    o_norm_red, o_norm_green, o_norm_blue, o_lightness;
    logic [8:0]    o_hue_degrees;
    logic [6:0]    o_saturation_pct;
    logic          o_clear_zero;
    int            fail_count, pending_count;
    int            idle_cycles = 0;
    bit            hold_off = 1'b0;
    bit            hold_done = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    rgbc_to_hsl_converter_top #(.COUNT_BITS(CB)) u_top (.*);

    rgbc_hsl_checker #(.COUNT_BITS(CB)) u_checker (.*);

    // Watchdog: end the run after a long stretch with no word moving
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: random stall per word, one long hold-off on request
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_ready <= 1'b0;
                repeat (150) @(negedge i_clk);
                hold_off = 1'b0;
                hold_done = 1'b1;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Offer one reading and hold it until accepted
    task automatic send_reading(logic [CB-1:0] rc, gc, bc, cc, bit may_gap);
        int gap;
        gap = may_gap ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_red_count <= rc;
        i_green_count <= gc;
        i_blue_count <= bc;
        i_clear_count <= cc;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    function automatic logic [CB-1:0] rand_count(logic [CB-1:0] clr);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return CB'($urandom_range(0, clr));
            3: return CB'($urandom);
            default: return CB'(($urandom_range(0, 300) * clr) / 255 +
                                $urandom_range(0, 3));
        endcase
    endfunction

    initial begin
        logic [CB-1:0] cc;
        bit burst;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: zero clear, grey, each hue sector, saturation, extremes
        send_reading(16'd100, 16'd200, 16'd300, 16'd0, 1'b0);
        send_reading('1, '1, '1, 16'd0, 1'b0);
        send_reading(16'd0, 16'd0, 16'd0, 16'd1, 1'b0);
        send_reading('1, '1, '1, '1, 1'b0);
        send_reading(16'd50, 16'd50, 16'd50, 16'd100, 1'b0);
        send_reading('1, 16'd0, 16'd0, 16'd1, 1'b0);
        send_reading(16'd0, '1, 16'd0, '1, 1'b0);
        send_reading(16'd0, 16'd0, '1, '1, 1'b0);
        send_reading(16'd255, 16'd0, 16'd1, 16'd255, 1'b0);   // hue wraps past 360
        send_reading(16'd255, 16'd100, 16'd200, 16'd255, 1'b0);
        send_reading(16'd20, 16'd255, 16'd30, 16'd255, 1'b0);
        send_reading(16'd10, 16'd5, 16'd254, 16'd255, 1'b0);
        send_reading(16'd255, 16'd254, 16'd255, 16'd255, 1'b0);
        send_reading(16'd128, 16'd126, 16'd127, 16'd255, 1'b0); // lightness near 127
        send_reading(16'd1, 16'd2, 16'd3, 16'd255, 1'b0);
        send_reading(16'hAAAA, 16'h5555, 16'h8000, 16'hFFFE, 1'b0);
        send_reading(16'h5555, 16'hAAAA, 16'h7FFF, '1, 1'b0);
        send_reading(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);

        // Random readings, some back-to-back bursts
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 300) hold_off = 1'b1;
            if (n == 600) begin
                // Pause until every expected word has come
                i_valid <= 1'b0;
                do @(negedge i_clk); while (pending_count != 0);
            end
            if (n % 40 == 0) burst = $urandom_range(0, 2) == 0;
            case ($urandom_range(0, 9))
                0: cc = '0;
                1: cc = '1;
                2: cc = CB'($urandom_range(1, 20));
                default: cc = CB'($urandom);
            endcase
            send_reading(rand_count(cc), rand_count(cc), rand_count(cc), cc,
                         !(burst || (n >= 300 && !hold_done)));
        end
        i_valid <= 1'b0;

        do @(negedge i_clk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
